// ===== hdl/wbps_pkg.sv =====
package wbps_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;
    localparam logic [1:0] REG_WILDCARD_MASK  = 2'd3;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int LEN_W         = 5;
    localparam int REG_POSITIONS = 16;
    localparam int POS_W         = 4;
    localparam int OUT_ADDR_W    = 20;

    typedef struct packed {
        logic shift;     // beat takes part in the scan
        logic clear_in;  // scan start: zero the byte coming from the neighbor
        logic active;    // cell lies inside the pattern length
        logic wild;      // pattern position of this cell matches any byte
    } cell_ctrl_t;

endpackage

// ===== hdl/wildcard_byte_pattern_search_core.sv =====
// A result beat appears on m_tvalid in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle; the whole cell row compares in the accepting cycle.
// The input stalls only while a result beat waits in the output register and m_tready is low.
// Reset (aresetn low at a rising edge): clears registers, window, byte count, done flag
// and the output register; the first beat after reset is taken as address zero.
module wildcard_byte_pattern_search_core #(
    parameter int PATTERN_MAX  = 16,
    parameter int ADDRESS_BITS = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wen,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] byte_value
    input  logic                              s_tuser,   // [0] scan_start
    input  logic                              s_tlast,   // scan_end
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [19:0] match_address, [23:20] zero
    output logic                              m_tuser    // [0] found
);
    import wbps_pkg::*;

    localparam int CAP = (PATTERN_MAX < REG_POSITIONS) ? PATTERN_MAX : REG_POSITIONS;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);
    localparam logic [ADDRESS_BITS:0] COUNT_MAX = '1;

    logic [LEN_W-1:0]       len_reg,  len_next;
    logic [63:0]            pat_lo_reg, pat_lo_next;
    logic [63:0]            pat_hi_reg, pat_hi_next;
    logic [15:0]            wild_reg, wild_next;
    logic [ADDRESS_BITS:0]  cnt_reg, cnt_next;
    logic                   finished_reg, finished_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg, m_found_next;
    logic [OUT_ADDR_W-1:0]  m_addr_reg, m_addr_next;

    logic                   s_accept;
    logic                   live;
    logic [LEN_W-1:0]       eff_len;
    logic [ADDRESS_BITS:0]  cnt_base;
    logic [ADDRESS_BITS:0]  cnt_inc;
    logic [ADDRESS_BITS:0]  start_addr;
    logic                   window_ok;
    logic                   hit;
    logic [127:0]           pat_all;

    logic [7:0]             cell_q     [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_match;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    // after the result of a scan, only a scan start brings the block back
    assign live     = s_accept && (s_tuser || !finished_reg);
    assign eff_len  = (len_reg > CAP_LEN) ? CAP_LEN : len_reg;
    assign pat_all  = {pat_hi_reg, pat_lo_reg};

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            cell_ctrl_t ctrl;
            logic [7:0] byte_in;
            logic [7:0] pattern_byte;

            if (k == 0) begin : g_head
                assign byte_in       = s_tdata;
                assign ctrl.clear_in = 1'b0;
            end else begin : g_body
                assign byte_in       = cell_q[k-1];
                assign ctrl.clear_in = s_tuser;
            end

            if (k < REG_POSITIONS) begin : g_cmp
                // window slot k holds pattern position len-1-k
                logic [LEN_W-1:0] pos;
                assign pos          = eff_len - LEN_W'(k + 1);
                assign ctrl.active  = eff_len > LEN_W'(k);
                assign ctrl.wild    = wild_reg[pos[POS_W-1:0]];
                assign pattern_byte = pat_all[pos[POS_W-1:0]*8 +: 8];
            end else begin : g_idle
                assign ctrl.active  = 1'b0;
                assign ctrl.wild    = 1'b0;
                assign pattern_byte = 8'h00;
            end

            assign ctrl.shift = live;

            wbps_cell u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl),
                .byte_in      (byte_in),
                .pattern_byte (pattern_byte),
                .byte_q       (cell_q[k]),
                .match        (cell_match[k])
            );
        end
    endgenerate

    assign window_ok  = &cell_match;
    assign cnt_base   = s_tuser ? '0 : cnt_reg;
    assign cnt_inc    = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 1'b1;
    assign start_addr = cnt_inc - (ADDRESS_BITS + 1)'(eff_len);
    assign hit        = (eff_len != '0)
                     && (cnt_inc >= (ADDRESS_BITS + 1)'(eff_len))
                     && (cnt_inc != COUNT_MAX)
                     && !start_addr[ADDRESS_BITS]
                     && window_ok;

    always_comb begin
        len_next    = len_reg;
        pat_lo_next = pat_lo_reg;
        pat_hi_next = pat_hi_reg;
        wild_next   = wild_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: len_next    = cfg_wdata[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_lo_next = cfg_wdata;
                REG_PATTERN_HIGH:   pat_hi_next = cfg_wdata;
                REG_WILDCARD_MASK:  wild_next   = cfg_wdata[15:0];
                default:            len_next    = len_reg;
            endcase
        end
    end

    always_comb begin
        cnt_next      = cnt_reg;
        finished_next = finished_reg;
        m_valid_next  = m_valid_reg;
        m_found_next  = m_found_reg;
        m_addr_next   = m_addr_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (live) begin
            cnt_next      = cnt_inc;
            finished_next = hit || s_tlast;
            if (hit || s_tlast) begin
                m_valid_next = 1'b1;
                m_found_next = hit;
                m_addr_next  = hit ? OUT_ADDR_W'(start_addr[ADDRESS_BITS-1:0]) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            pat_lo_reg   <= '0;
            pat_hi_reg   <= '0;
            wild_reg     <= '0;
            cnt_reg      <= '0;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_found_reg  <= 1'b0;
            m_addr_reg   <= '0;
        end else begin
            len_reg      <= len_next;
            pat_lo_reg   <= pat_lo_next;
            pat_hi_reg   <= pat_hi_next;
            wild_reg     <= wild_next;
            cnt_reg      <= cnt_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
            m_found_reg  <= m_found_next;
            m_addr_reg   <= m_addr_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {4'h0, m_addr_reg};

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found beat carries a nonzero address");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg && !(s_accept && s_tuser) |=> finished_reg)
        else $error("done flag dropped without a scan start");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        live && (hit || s_tlast) |=> m_tvalid)
        else $error("result beat not presented");

    a_done_from_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        !finished_reg ##1 finished_reg |-> $past(s_accept))
        else $error("done flag set without an input beat");

endmodule

// ===== hdl/wbps_cell.sv =====
module wbps_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wbps_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]           byte_in,
    input  logic [7:0]           pattern_byte,
    output logic [7:0]           byte_q,
    output logic                 match
);
    import wbps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [7:0] incoming;

    assign incoming = ctrl.clear_in ? 8'h00 : byte_in;

    // compare against the byte this cell holds after the shift
    assign match  = !ctrl.active || ctrl.wild || (incoming == pattern_byte);
    assign byte_q = byte_reg;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.shift) begin
            byte_next = incoming;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

endmodule
